FILE: rtl/assert_macros.svh
// Assertion macros for the checker file of the list store.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication under reset
`define PLSU_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("list store: same-cycle check failed");

// Next-cycle implication under reset
`define PLSU_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("list store: next-cycle check failed");

`endif

FILE: rtl/plsu_pkg.sv
// Shared types and request codes of the positional list store.
// No dependencies; imported by the controller and the top level.
`default_nettype none

package plsu_pkg;

  // Width of the request and result payload fields
  localparam int KIND_W = 4;
  localparam int POS_W  = 4;
  localparam int WORD_W = 32;

  // Request kinds
  localparam logic [KIND_W-1:0] KIND_INS_FRONT = 4'd0;
  localparam logic [KIND_W-1:0] KIND_INS_BACK  = 4'd1;
  localparam logic [KIND_W-1:0] KIND_INS_AT    = 4'd2;
  localparam logic [KIND_W-1:0] KIND_REM_FRONT = 4'd3;
  localparam logic [KIND_W-1:0] KIND_REM_BACK  = 4'd4;
  localparam logic [KIND_W-1:0] KIND_REM_AT    = 4'd5;
  localparam logic [KIND_W-1:0] KIND_RD_FRONT  = 4'd6;
  localparam logic [KIND_W-1:0] KIND_RD_BACK   = 4'd7;
  localparam logic [KIND_W-1:0] KIND_RD_AT     = 4'd8;
  localparam logic [KIND_W-1:0] KIND_CLEAR     = 4'd9;

  // Finished result handed from the controller to the output stage
  typedef struct packed {
    logic              valid;
    logic              ok;
    logic [WORD_W-1:0] value;
  } plsu_res_t;

endpackage

`default_nettype wire

FILE: rtl/plsu_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module plsu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/plsu_ctrl.sv
// Sequencer of the list store: decodes a request and shifts words through the RAM
// one at a time with a shared +/-1 index unit. Depends on plsu_pkg.
`default_nettype none

module plsu_ctrl import plsu_pkg::*; #(
  parameter int CAPACITY   = 16,
  parameter int DATA_WIDTH = 32,
  localparam int AW = $clog2(CAPACITY),
  localparam int CW = $clog2(CAPACITY + 1)
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // request side
  input  wire logic                  start_i,
  input  wire logic [KIND_W-1:0]     kind_i,
  input  wire logic [POS_W-1:0]      position_i,
  input  wire logic [WORD_W-1:0]     data_in_i,
  output logic                       busy_o,
  // RAM side
  output logic                       ram_we_o,
  output logic [AW-1:0]              ram_waddr_o,
  output logic [DATA_WIDTH-1:0]      ram_wdata_o,
  output logic                       ram_re_o,
  output logic [AW-1:0]              ram_raddr_o,
  input  wire logic [DATA_WIDTH-1:0] ram_rdata_i,
  // result side
  output plsu_res_t                  res_o,
  output logic [CW-1:0]              count_o,
  input  wire logic                  res_ack_i
);

  localparam int CMPW = (CW > POS_W) ? CW : POS_W;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_GRAB = 5'b00010,
    ST_STEP = 5'b00100,
    ST_MOVE = 5'b01000,
    ST_DONE = 5'b10000
  } st_e;

  typedef enum logic [1:0] {
    OP_INS = 2'd0,
    OP_REM = 2'd1,
    OP_RD  = 2'd2
  } op_e;

  st_e                   state_q, state_d;
  op_e                   op_q, op_d;
  logic [CW-1:0]         cnt_q, cnt_d;
  logic [CW-1:0]         cur_q, cur_d;
  logic [CW-1:0]         stop_q, stop_d;
  logic [DATA_WIDTH-1:0] data_q, data_d;
  logic [DATA_WIDTH-1:0] val_q, val_d;
  logic                  ok_q, ok_d;

  logic          full, empty, pos_ok;
  logic [CW-1:0] last, pos_t, nxt;

  // Request checks against the current length
  assign full   = (cnt_q >= CW'(CAPACITY));
  assign empty  = (cnt_q == '0);
  assign pos_ok = (CMPW'(position_i) < CMPW'(cnt_q));
  assign last   = cnt_q - CW'(1);
  assign pos_t  = CW'(position_i);

  // Shared index unit: walks down for inserts, up for removes
  assign nxt = (op_q == OP_INS) ? (cur_q - CW'(1)) : (cur_q + CW'(1));

  // Sequencer
  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    cnt_d       = cnt_q;
    cur_d       = cur_q;
    stop_d      = stop_q;
    data_d      = data_q;
    val_d       = val_q;
    ok_d        = ok_q;
    ram_we_o    = 1'b0;
    ram_waddr_o = cur_q[AW-1:0];
    ram_wdata_o = ram_rdata_i;
    ram_re_o    = 1'b0;
    ram_raddr_o = nxt[AW-1:0];

    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          val_d   = '0;
          ok_d    = 1'b0;
          data_d  = DATA_WIDTH'(data_in_i);
          state_d = ST_DONE;
          unique case (kind_i) inside
            KIND_INS_FRONT, KIND_INS_BACK, KIND_INS_AT: begin
              // shift from the back down to the target, then drop the word in
              op_d  = OP_INS;
              cur_d = cnt_q;
              unique case (kind_i)
                KIND_INS_FRONT: stop_d = '0;
                KIND_INS_BACK:  stop_d = cnt_q;
                default:        stop_d = pos_t;
              endcase
              if (!full && (kind_i != KIND_INS_AT || pos_ok)) begin
                state_d = ST_STEP;
              end
            end
            KIND_REM_FRONT, KIND_REM_BACK, KIND_REM_AT,
            KIND_RD_FRONT, KIND_RD_BACK, KIND_RD_AT: begin
              op_d   = (kind_i inside {KIND_REM_FRONT, KIND_REM_BACK, KIND_REM_AT}) ?
                       OP_REM : OP_RD;
              stop_d = last;
              unique case (kind_i) inside
                KIND_REM_FRONT, KIND_RD_FRONT: cur_d = '0;
                KIND_REM_BACK, KIND_RD_BACK:   cur_d = last;
                default:                       cur_d = pos_t;
              endcase
              ram_raddr_o = cur_d[AW-1:0];
              if ((kind_i inside {KIND_REM_AT, KIND_RD_AT}) ? pos_ok : !empty) begin
                ram_re_o = 1'b1;
                state_d  = ST_GRAB;
              end
            end
            KIND_CLEAR: begin
              cnt_d = '0;
              ok_d  = 1'b1;
            end
            default: begin
              ok_d = 1'b0;
            end
          endcase
        end
      end
      ST_GRAB: begin
        // word at the target is now on the RAM output
        val_d = ram_rdata_i;
        if (op_q == OP_RD) begin
          ok_d    = 1'b1;
          state_d = ST_DONE;
        end else begin
          state_d = ST_STEP;
        end
      end
      ST_STEP: begin
        if (cur_q == stop_q) begin
          ok_d    = 1'b1;
          state_d = ST_DONE;
          if (op_q == OP_INS) begin
            ram_we_o    = 1'b1;
            ram_wdata_o = data_q;
            cnt_d       = cnt_q + CW'(1);
          end else begin
            cnt_d = last;
          end
        end else begin
          ram_re_o = 1'b1;
          state_d  = ST_MOVE;
        end
      end
      ST_MOVE: begin
        // neighbor word lands one slot over
        ram_we_o = 1'b1;
        cur_d    = nxt;
        state_d  = ST_STEP;
      end
      ST_DONE: begin
        if (res_ack_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    cur_q  <= cur_d;
    stop_q <= stop_d;
    data_q <= data_d;
    val_q  <= val_d;
    ok_q   <= ok_d;
  end

  assign busy_o      = (state_q != ST_IDLE);
  assign res_o.valid = (state_q == ST_DONE);
  assign res_o.ok    = ok_q;
  assign res_o.value = WORD_W'(val_q);
  assign count_o     = cnt_q;

endmodule

`default_nettype wire

FILE: rtl/positional_list_store_unit.sv
// Positional list store: an ordered list of up to CAPACITY words, front at slot 0,
// with insert, remove and read at the front, the back or a position, and clear.
// One item is worked at a time; in_stall_o is high from the cycle after acceptance
// until its result has moved into the output register. The words live in one RAM
// with one write and one registered read port, and an insert or remove shifts the
// words behind the target one slot at a time, each read in a STEP state and written
// one slot over in a MOVE state. A read fetches only the target word, and a clear or
// failed request goes straight to its result. No clearing pass runs after reset.
// Depends on plsu_pkg, plsu_ram and plsu_ctrl.
`default_nettype none

module positional_list_store_unit import plsu_pkg::*; #(
  parameter int CAPACITY   = 16,
  parameter int DATA_WIDTH = 32,
  localparam int CW = $clog2(CAPACITY + 1)
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // request channel
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic [KIND_W-1:0] kind_i,
  input  wire logic [POS_W-1:0]  position_i,
  input  wire logic [WORD_W-1:0] data_in_i,
  // result channel
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic                   ok_o,
  output logic [WORD_W-1:0]      read_value_o,
  output logic [CW-1:0]          count_o
);

  localparam int AW = $clog2(CAPACITY);

  logic                  ram_we, ram_re;
  logic [AW-1:0]         ram_waddr, ram_raddr;
  logic [DATA_WIDTH-1:0] ram_wdata, ram_rdata;
  plsu_res_t             res;
  logic [CW-1:0]         cnt;
  logic                  busy, res_ack;

  logic              out_valid_q, out_valid_d;
  logic              ok_q;
  logic [WORD_W-1:0] val_q;
  logic [CW-1:0]     count_q;

  plsu_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  plsu_ctrl #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (in_valid_i),
    .kind_i      (kind_i),
    .position_i  (position_i),
    .data_in_i   (data_in_i),
    .busy_o      (busy),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata),
    .res_o       (res),
    .count_o     (cnt),
    .res_ack_i   (res_ack)
  );

  // Output register takes a result when empty or being drained
  assign res_ack = res.valid && (!out_valid_q || !out_stall_i);

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_ack) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ack) begin
      ok_q    <= res.ok;
      val_q   <= res.value;
      count_q <= cnt;
    end
  end

  assign in_stall_o   = busy;
  assign out_valid_o  = out_valid_q;
  assign ok_o         = ok_q;
  assign read_value_o = val_q;
  assign count_o      = count_q;

endmodule

`default_nettype wire

FILE: rtl/plsu_checker.sv
// Port-level checks of the list store, bound to the top level.
// Depends on assert_macros.svh and plsu_pkg.
`default_nettype none
`include "assert_macros.svh"

module plsu_checker import plsu_pkg::*; #(
  parameter int CAPACITY = 16,
  localparam int CW = $clog2(CAPACITY + 1)
) (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_valid_i,
  input wire logic              in_stall_o,
  input wire logic              out_valid_o,
  input wire logic              out_stall_i,
  input wire logic              ok_o,
  input wire logic [WORD_W-1:0] read_value_o,
  input wire logic [CW-1:0]     count_o
);

  // one item at a time: busy right after acceptance
  `PLSU_ASSERT_NXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)
  // length never passes the capacity
  `PLSU_ASSERT_IMP(a_count_in_range, clk_i, rst_ni, out_valid_o, count_o <= CW'(CAPACITY))
  // a failed item carries no word
  `PLSU_ASSERT_IMP(a_fail_reads_zero, clk_i, rst_ni, out_valid_o && !ok_o, read_value_o == '0)
  // a stalled item holds
  `PLSU_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i,
                   out_valid_o && $stable(ok_o) && $stable(read_value_o) && $stable(count_o))

endmodule

bind positional_list_store_unit plsu_checker #(.CAPACITY(CAPACITY)) u_checker (.*);

`default_nettype wire

FILE: bench/positional_list_store_unit_tb.sv
// Testbench for the positional list store: drives insert, remove, read and clear items
// and checks every result against a software mirror of the list. Depends on plsu_pkg
// and positional_list_store_unit.
`default_nettype none

module positional_list_store_unit_tb;
  import plsu_pkg::*;

  localparam int CAPACITY    = 16;
  localparam int DATA_WIDTH  = 32;
  localparam int CNT_W       = $clog2(CAPACITY + 1);
  localparam int RANDOM_N    = 552;
  localparam int CYCLE_LIMIT = 200000;
  // worst-case block latency, used for the quiet period at the end
  localparam int DRAIN_WAIT  = 2 * CAPACITY + 8;

  // codes the block does not define; they must fail and change nothing
  localparam logic [KIND_W-1:0] KIND_UNUSED_LO = 4'd10;
  localparam logic [KIND_W-1:0] KIND_UNUSED_HI = 4'd15;

  typedef struct packed {
    logic              ok;
    logic [WORD_W-1:0] value;
    logic [CNT_W-1:0]  count;
  } list_result_t;

  // Mirror of the stored list; predicts one result per accepted item
  class list_mirror;
    logic [DATA_WIDTH-1:0] slots [CAPACITY];
    int unsigned           length;
    int unsigned           peak;
    list_result_t          expected_q[$];
    int unsigned           errors;
    int unsigned           checked;

    function new();
      length  = 0;
      peak    = 0;
      errors  = 0;
      checked = 0;
    endfunction

    function void shift_in(int unsigned idx, logic [WORD_W-1:0] word);
      for (int unsigned i = length; i > idx; i--) slots[i] = slots[i-1];
      slots[idx] = word[DATA_WIDTH-1:0];
      length++;
      if (length > peak) peak = length;
    endfunction

    function logic [WORD_W-1:0] take_out(int unsigned idx);
      logic [WORD_W-1:0] word;
      word = WORD_W'(slots[idx]);
      for (int unsigned i = idx; i + 1 < length; i++) slots[i] = slots[i+1];
      length--;
      return word;
    endfunction

    // Work out the result of one accepted item and queue it
    function void note_request(logic [KIND_W-1:0] kind, logic [POS_W-1:0] pos,
                               logic [WORD_W-1:0] word);
      list_result_t res;
      bit           full;
      bit           empty;
      bit           in_range;
      int unsigned  at;
      res      = '0;
      at       = 32'(pos);
      full     = (length >= CAPACITY);
      empty    = (length == 0);
      in_range = (at < length);
      case (kind)
        KIND_INS_FRONT: if (!full) begin
          shift_in(0, word);
          res.ok = 1'b1;
        end
        KIND_INS_BACK: if (!full) begin
          shift_in(length, word);
          res.ok = 1'b1;
        end
        KIND_INS_AT: if (!full && in_range) begin
          shift_in(at, word);
          res.ok = 1'b1;
        end
        KIND_REM_FRONT: if (!empty) begin
          res.value = take_out(0);
          res.ok    = 1'b1;
        end
        KIND_REM_BACK: if (!empty) begin
          res.value = take_out(length - 1);
          res.ok    = 1'b1;
        end
        KIND_REM_AT: if (in_range) begin
          res.value = take_out(at);
          res.ok    = 1'b1;
        end
        KIND_RD_FRONT: if (!empty) begin
          res.value = WORD_W'(slots[0]);
          res.ok    = 1'b1;
        end
        KIND_RD_BACK: if (!empty) begin
          res.value = WORD_W'(slots[length-1]);
          res.ok    = 1'b1;
        end
        KIND_RD_AT: if (in_range) begin
          res.value = WORD_W'(slots[at]);
          res.ok    = 1'b1;
        end
        KIND_CLEAR: begin
          length = 0;
          res.ok = 1'b1;
        end
        default: ;
      endcase
      res.count = CNT_W'(length);
      expected_q.push_back(res);
    endfunction

    task report(string msg);
      $display("MISMATCH: %s", msg);
      errors++;
    endtask

    // Compare one accepted result with the oldest prediction
    task check_result(logic ok, logic [WORD_W-1:0] value, logic [CNT_W-1:0] count);
      list_result_t exp;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected result ok=%0b value=%h count=%0d", ok, value, count));
      end else begin
        exp = expected_q.pop_front();
        checked++;
        if (ok !== exp.ok)
          report($sformatf("result %0d ok=%0b, want %0b", checked, ok, exp.ok));
        if (value !== exp.value)
          report($sformatf("result %0d value=%h, want %h", checked, value, exp.value));
        if (count !== exp.count)
          report($sformatf("result %0d count=%0d, want %0d", checked, count, exp.count));
      end
    endtask
  endclass

  logic              clk_i        = 1'b0;
  logic              rst_ni       = 1'b0;
  logic              in_valid_i   = 1'b0;
  logic [KIND_W-1:0] kind_i       = '0;
  logic [POS_W-1:0]  position_i   = '0;
  logic [WORD_W-1:0] data_in_i    = '0;
  logic              out_stall_i  = 1'b0;
  logic              in_stall_o;
  logic              out_valid_o;
  logic              ok_o;
  logic [WORD_W-1:0] read_value_o;
  logic [CNT_W-1:0]  count_o;

  list_mirror  mirror;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned items_sent     = 0;
  int unsigned cycle_count    = 0;

  positional_list_store_unit #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .kind_i       (kind_i),
    .position_i   (position_i),
    .data_in_i    (data_in_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .ok_o         (ok_o),
    .read_value_o (read_value_o),
    .count_o      (count_o)
  );

  always #5 clk_i = ~clk_i;

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results pending", cycle_count,
               mirror.expected_q.size());
      $display("Verification failed");
      $finish;
    end
  end

  // Result side: check accepted items, stall at random
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      mirror.check_result(ok_o, read_value_o, count_o);
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  // Present one item, with optional idle cycles first, and hold it until accepted
  task automatic push_request(input logic [KIND_W-1:0] kind, input logic [POS_W-1:0] pos,
                              input logic [WORD_W-1:0] word);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i     <= kind;
    position_i <= pos;
    data_in_i  <= word;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    mirror.note_request(kind, pos, word);
    items_sent++;
  endtask

  initial begin
    int unsigned       pick;
    bit                filling;
    logic [KIND_W-1:0] kind;
    logic [POS_W-1:0]  pos;
    mirror  = new();
    filling = 1'b1;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty list failures and unused kinds
    push_request(KIND_RD_FRONT,  4'd0,  32'h0);
    push_request(KIND_REM_BACK,  4'd0,  32'h0);
    push_request(KIND_REM_AT,    4'd0,  32'h0);
    push_request(KIND_RD_AT,     4'd0,  32'h0);
    push_request(KIND_INS_AT,    4'd0,  32'h1234_5678);
    push_request(KIND_UNUSED_LO, 4'd5,  32'hFFFF_FFFF);
    push_request(KIND_UNUSED_HI, 4'd15, 32'hFFFF_FFFF);
    // build a short list with extreme words; position is ignored by plain inserts
    push_request(KIND_INS_BACK,  4'd15, 32'h0000_0000);
    push_request(KIND_INS_FRONT, 4'd15, 32'hFFFF_FFFF);
    push_request(KIND_INS_AT,    4'd1,  32'hA5A5_A5A5);
    push_request(KIND_INS_BACK,  4'd0,  32'h5A5A_5A5A);
    // reads, including the last valid position and one past the end
    push_request(KIND_RD_FRONT,  4'd0,  32'h0);
    push_request(KIND_RD_BACK,   4'd0,  32'h0);
    push_request(KIND_RD_AT,     4'd3,  32'h0);
    push_request(KIND_RD_AT,     4'd4,  32'h0);
    push_request(KIND_INS_AT,    4'd15, 32'hDEAD_BEEF);
    push_request(KIND_REM_AT,    4'd15, 32'h0);
    push_request(KIND_UNUSED_LO, 4'd0,  32'h0);
    // removes from every place, then clear
    push_request(KIND_REM_AT,    4'd1,  32'h0);
    push_request(KIND_REM_FRONT, 4'd0,  32'h0);
    push_request(KIND_REM_BACK,  4'd0,  32'h0);
    push_request(KIND_CLEAR,     4'd0,  32'h0);
    push_request(KIND_CLEAR,     4'd0,  32'h0);

    // Random: swing the list between empty and full under four handshake phases
    for (int n = 0; n < RANDOM_N; n++) begin
      case (n / (RANDOM_N / 4))
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 52; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 52; end
        default: begin send_idle_pct = 11; recv_stall_pct = 11; end
      endcase
      // turn around at the ends, lingering a little so full and empty get hit
      if (mirror.length == CAPACITY && $urandom_range(3) == 0) filling = 1'b0;
      if (mirror.length == 0 && $urandom_range(3) == 0)        filling = 1'b1;

      pick = $urandom_range(99);
      if (pick < 2)
        kind = KIND_CLEAR;
      else if (pick < 5)
        kind = KIND_W'($urandom_range(KIND_UNUSED_HI, KIND_UNUSED_LO));
      else if (pick < (filling ? 65 : 25))
        kind = KIND_W'($urandom_range(KIND_INS_AT, KIND_INS_FRONT));
      else if (pick < 86)
        kind = KIND_W'($urandom_range(KIND_REM_AT, KIND_REM_FRONT));
      else
        kind = KIND_W'($urandom_range(KIND_RD_AT, KIND_RD_FRONT));

      // mostly positions inside the list, sometimes anything
      if (mirror.length == 0 || $urandom_range(9) == 0)
        pos = POS_W'($urandom_range(15));
      else
        pos = POS_W'($urandom_range(mirror.length - 1));

      push_request(kind, pos, $urandom);
    end
    in_valid_i     <= 1'b0;
    recv_stall_pct  = 0;

    // Drain, then watch for stray results
    while (mirror.expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    $display("Sent %0d items (directed, then random under four idle/stall mixes).",
             items_sent);
    $display("Compared %0d results, peak list length %0d of %0d, %0d mismatches.",
             mirror.checked, mirror.peak, CAPACITY, mirror.errors);
    if (mirror.errors == 0 && mirror.expected_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
